/* sv/fbac_pkg.sv */
package fbac_pkg;

  localparam int MemWords = 4096;
  localparam int MemAw    = $clog2(MemWords);
  localparam int WordW    = 40;
  localparam int HalfW    = 20;
  localparam int AddrW    = 12;
  localparam int OpcW     = 8;

  // host operation codes; code 3 has no meaning
  typedef enum logic [1:0] {
    OpWrite = 2'd0,
    OpRead  = 2'd1,
    OpExec  = 2'd2
  } op_e;

  typedef enum logic [OpcW-1:0] {
    OpcLoad = 8'd1,
    OpcAdd  = 8'd5,
    OpcSub  = 8'd6,
    OpcJump = 8'd15,
    OpcStor = 8'd33
  } opc_e;

  typedef enum logic [2:0] {
    StIdle,
    StFetch,
    StExec,
    StOperand,
    StResp
  } state_e;

  typedef struct packed {
    logic             we;
    logic             re;
    logic [MemAw-1:0] addr;
    logic [WordW-1:0] wdata;
  } mem_req_t;

endpackage

/* sv/fbac_in_if.sv */
interface fbac_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   op;
  logic [fbac_pkg::AddrW-1:0]   addr;
  logic [fbac_pkg::WordW-1:0]   data;

  modport source (output valid, output op, output addr, output data, input ready);
  modport sink   (input valid, input op, input addr, input data, output ready);
endinterface

/* sv/fbac_out_if.sv */
interface fbac_out_if;
  logic                              valid;
  logic                              ready;
  logic [fbac_pkg::WordW-1:0]        read_data;
  logic [fbac_pkg::AddrW-1:0]        prog_counter;
  logic [fbac_pkg::OpcW-1:0]         opcode_now;
  logic [fbac_pkg::AddrW-1:0]        operand_addr;
  logic signed [fbac_pkg::WordW-1:0] accum;
  logic [fbac_pkg::WordW-1:0]        buffer_word;
  logic                              executed;
  logic                              halted;

  modport source (output valid, output read_data, output prog_counter, output opcode_now,
                  output operand_addr, output accum, output buffer_word, output executed,
                  output halted, input ready);
  modport sink   (input valid, input read_data, input prog_counter, input opcode_now,
                  input operand_addr, input accum, input buffer_word, input executed,
                  input halted, output ready);
endinterface

/* sv/fbac_ram.sv */
module fbac_ram #(
  parameter int Width = 40,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    // hold read data until the next read
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/fbac_core.sv */
module fbac_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  fbac_in_if.sink                  in_i,
  fbac_out_if.source               out_o,
  output fbac_pkg::mem_req_t       mem_req_o,
  input  logic [fbac_pkg::WordW-1:0] mem_rdata_i
);
  import fbac_pkg::*;

  state_e             state_q, state_d;
  logic [AddrW-1:0]   pc_q, pc_d;
  logic [HalfW-1:0]   buf_q, buf_d;
  logic               buf_full_q, buf_full_d;
  logic [WordW-1:0]   acc_q, acc_d;
  logic [WordW-1:0]   mbr_q, mbr_d;
  logic [OpcW-1:0]    ir_q, ir_d;
  logic [AddrW-1:0]   mar_q, mar_d;
  logic               halt_q, halt_d;
  logic               ran_q, ran_d;
  logic               rd_sel_q, rd_sel_d;
  logic               rd_ok_q, rd_ok_d;

  logic               out_valid_q, out_valid_d;
  logic [WordW-1:0]   o_rdata_q, o_rdata_d;
  logic [AddrW-1:0]   o_pc_q, o_pc_d;
  logic [OpcW-1:0]    o_opc_q, o_opc_d;
  logic [AddrW-1:0]   o_adr_q, o_adr_d;
  logic [WordW-1:0]   o_acc_q, o_acc_d;
  logic [WordW-1:0]   o_mbr_q, o_mbr_d;
  logic               o_ran_q, o_ran_d;
  logic               o_halt_q, o_halt_d;

  logic [WordW-1:0]   rd_word;

  function automatic logic in_range(logic [AddrW-1:0] a);
    return {1'b0, a} < (AddrW+1)'(MemWords);
  endfunction

  assign rd_word = rd_ok_q ? mem_rdata_i : '0;
  assign in_i.ready = (state_q == StIdle);

  always_comb begin
    state_d     = state_q;
    pc_d        = pc_q;
    buf_d       = buf_q;
    buf_full_d  = buf_full_q;
    acc_d       = acc_q;
    mbr_d       = mbr_q;
    ir_d        = ir_q;
    mar_d       = mar_q;
    halt_d      = halt_q;
    ran_d       = ran_q;
    rd_sel_d    = rd_sel_q;
    rd_ok_d     = rd_ok_q;
    out_valid_d = out_valid_q && !out_o.ready;
    o_rdata_d   = o_rdata_q;
    o_pc_d      = o_pc_q;
    o_opc_d     = o_opc_q;
    o_adr_d     = o_adr_q;
    o_acc_d     = o_acc_q;
    o_mbr_d     = o_mbr_q;
    o_ran_d     = o_ran_q;
    o_halt_d    = o_halt_q;
    mem_req_o   = '0;

    case (state_q)
      StIdle: begin
        if (in_i.valid) begin
          ran_d    = 1'b0;
          rd_sel_d = 1'b0;
          state_d  = StResp;
          case (op_e'(in_i.op))
            OpWrite: begin
              mem_req_o.we    = in_range(in_i.addr);
              mem_req_o.addr  = in_i.addr[MemAw-1:0];
              mem_req_o.wdata = in_i.data;
            end
            OpRead: begin
              mem_req_o.re   = 1'b1;
              mem_req_o.addr = in_i.addr[MemAw-1:0];
              rd_ok_d        = in_range(in_i.addr);
              rd_sel_d       = 1'b1;
            end
            OpExec: begin
              if (!halt_q) begin
                if (buf_full_q) begin
                  ir_d       = buf_q[HalfW-1:AddrW];
                  mar_d      = buf_q[AddrW-1:0];
                  buf_d      = '0;
                  buf_full_d = 1'b0;
                  pc_d       = pc_q + AddrW'(1);
                  ran_d      = 1'b1;
                  state_d    = StExec;
                end else begin
                  mem_req_o.re   = 1'b1;
                  mem_req_o.addr = pc_q[MemAw-1:0];
                  rd_ok_d        = in_range(pc_q);
                  mar_d          = pc_q;
                  state_d        = StFetch;
                end
              end
            end
            default: ;
          endcase
        end
      end

      StFetch: begin
        mbr_d = rd_word;
        if (rd_word == '0) begin
          halt_d  = 1'b1;
          state_d = StResp;
        end else if (rd_word[HalfW-1:0] != '0) begin
          // run the low half first, park the high half
          buf_d      = rd_word[WordW-1:HalfW];
          buf_full_d = 1'b1;
          ir_d       = rd_word[HalfW-1:AddrW];
          mar_d      = rd_word[AddrW-1:0];
          ran_d      = 1'b1;
          state_d    = StExec;
        end else begin
          pc_d    = pc_q + AddrW'(1);
          ir_d    = rd_word[WordW-1:WordW-OpcW];
          mar_d   = rd_word[HalfW+AddrW-1:HalfW];
          ran_d   = 1'b1;
          state_d = StExec;
        end
      end

      StExec: begin
        state_d = StResp;
        case (opc_e'(ir_q))
          OpcLoad, OpcAdd, OpcSub: begin
            mem_req_o.re   = 1'b1;
            mem_req_o.addr = mar_q[MemAw-1:0];
            rd_ok_d        = in_range(mar_q);
            state_d        = StOperand;
          end
          OpcStor: begin
            mbr_d           = acc_q;
            mem_req_o.we    = in_range(mar_q);
            mem_req_o.addr  = mar_q[MemAw-1:0];
            mem_req_o.wdata = acc_q;
          end
          OpcJump: begin
            if (!acc_q[WordW-1]) begin
              pc_d       = mar_q;
              buf_d      = '0;
              buf_full_d = 1'b0;
            end
          end
          default: ;
        endcase
      end

      StOperand: begin
        mbr_d   = rd_word;
        state_d = StResp;
        case (opc_e'(ir_q))
          OpcLoad: acc_d = rd_word;
          OpcAdd:  acc_d = acc_q + rd_word;
          OpcSub:  acc_d = acc_q - rd_word;
          default: ;
        endcase
      end

      StResp: begin
        // wait for a free output slot
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          o_rdata_d   = rd_sel_q ? rd_word : '0;
          o_pc_d      = pc_q;
          o_opc_d     = ran_q ? ir_q : '0;
          o_adr_d     = ran_q ? mar_q : '0;
          o_acc_d     = acc_q;
          o_mbr_d     = mbr_q;
          o_ran_d     = ran_q;
          o_halt_d    = halt_q;
          state_d     = StIdle;
        end
      end

      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      pc_q        <= '0;
      buf_q       <= '0;
      buf_full_q  <= 1'b0;
      acc_q       <= '0;
      mbr_q       <= '0;
      ir_q        <= '0;
      mar_q       <= '0;
      halt_q      <= 1'b0;
      ran_q       <= 1'b0;
      rd_sel_q    <= 1'b0;
      rd_ok_q     <= 1'b0;
      out_valid_q <= 1'b0;
      o_rdata_q   <= '0;
      o_pc_q      <= '0;
      o_opc_q     <= '0;
      o_adr_q     <= '0;
      o_acc_q     <= '0;
      o_mbr_q     <= '0;
      o_ran_q     <= 1'b0;
      o_halt_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      buf_q       <= buf_d;
      buf_full_q  <= buf_full_d;
      acc_q       <= acc_d;
      mbr_q       <= mbr_d;
      ir_q        <= ir_d;
      mar_q       <= mar_d;
      halt_q      <= halt_d;
      ran_q       <= ran_d;
      rd_sel_q    <= rd_sel_d;
      rd_ok_q     <= rd_ok_d;
      out_valid_q <= out_valid_d;
      o_rdata_q   <= o_rdata_d;
      o_pc_q      <= o_pc_d;
      o_opc_q     <= o_opc_d;
      o_adr_q     <= o_adr_d;
      o_acc_q     <= o_acc_d;
      o_mbr_q     <= o_mbr_d;
      o_ran_q     <= o_ran_d;
      o_halt_q    <= o_halt_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.read_data    = o_rdata_q;
  assign out_o.prog_counter = o_pc_q;
  assign out_o.opcode_now   = o_opc_q;
  assign out_o.operand_addr = o_adr_q;
  assign out_o.accum        = $signed(o_acc_q);
  assign out_o.buffer_word  = o_mbr_q;
  assign out_o.executed     = o_ran_q;
  assign out_o.halted       = o_halt_q;

endmodule

/* sv/forty_bit_accumulator_cpu_top.sv */
// 40-bit accumulator machine with a 4096-word main store.
// in_i carries one command beat: op selects a host write of data to addr, a host read of
// addr, or the execution of one instruction. out_o returns exactly one result beat per
// command: read data, PC, executed opcode and address, accumulator, buffer register,
// executed and halted flags.
// Commands run one at a time through a small sequencer around a single-port RAM with a
// registered read; the sequencer steps through its states in this order:
//   host write or read, halted execute: StIdle, StResp
//   buffered instruction: StIdle, StExec, [StOperand for LOAD, ADD, SUB,] StResp
//   fetch: StIdle, StFetch, StExec, [StOperand,] StResp; a zero word halts in StFetch
// The result is loaded into an output register from StResp once the output slot is free.
// When the receiver stalls, the result is held in the output register and in_i.ready
// drops only while a command is in flight; a finished command whose result cannot yet be
// placed waits until the output register frees.
// Reset clears PC, accumulator, buffer and halt flag; the main store keeps no reset
// value and must be written by the host before it is read or fetched.
module forty_bit_accumulator_cpu_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  fbac_in_if.sink    in_i,
  fbac_out_if.source out_o
);
  import fbac_pkg::*;

  mem_req_t         mem_req;
  logic [WordW-1:0] mem_rdata;

  fbac_ram #(
    .Width (WordW),
    .Depth (MemWords)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .re_i    (mem_req.re),
    .addr_i  (mem_req.addr),
    .wdata_i (mem_req.wdata),
    .rdata_o (mem_rdata)
  );

  fbac_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  a_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_req.we && mem_req.re))
    else $error("RAM read and write in the same cycle");

  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("command accepted while another is in flight");

  a_idle_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.executed) |-> (out_o.opcode_now == '0 && out_o.operand_addr == '0))
    else $error("instruction fields set on a beat that executed nothing");

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.halted |=> out_o.halted)
    else $error("halted flag cleared without reset");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import fbac_pkg::*;

  localparam logic [1:0] OpUnused   = 2'd3;
  localparam int         CycleLimit = 500000;

  typedef struct packed {
    logic [WordW-1:0] read_data;
    logic [AddrW-1:0] prog_counter;
    logic [OpcW-1:0]  opcode_now;
    logic [AddrW-1:0] operand_addr;
    logic [WordW-1:0] accum;
    logic [WordW-1:0] buffer_word;
    logic             executed;
    logic             halted;
  } cpu_result_t;

  // Machine state mirror plus the queue of results still owed by the block.
  class cpu_scoreboard;
    bit [WordW-1:0] store   [MemWords];
    bit             written [MemWords];
    bit [AddrW-1:0] pc;
    bit [HalfW-1:0] held_half;
    bit             held_full;
    bit [WordW-1:0] acc;
    bit [WordW-1:0] mbr;
    bit [OpcW-1:0]  ir;
    bit [AddrW-1:0] mar;
    bit             halt;
    cpu_result_t    expected_q[$];
    int             errors;

    function bit [WordW-1:0] load_word(bit [AddrW-1:0] a);
      return written[a] ? store[a] : '0;
    endfunction

    function void store_word(bit [AddrW-1:0] a, bit [WordW-1:0] d);
      store[a]   = d;
      written[a] = 1'b1;
    endfunction

    function void run_instr(bit [OpcW-1:0] opc, bit [AddrW-1:0] a);
      ir  = opc;
      mar = a;
      case (opc)
        OpcLoad: begin
          mbr = load_word(a);
          acc = mbr;
        end
        OpcStor: begin
          mbr = acc;
          store_word(a, mbr);
        end
        OpcAdd: begin
          mbr = load_word(a);
          acc = acc + mbr;
        end
        OpcSub: begin
          mbr = load_word(a);
          acc = acc - mbr;
        end
        OpcJump: begin
          // taken jump drops whatever half is waiting
          if (!acc[WordW-1]) begin
            pc        = a;
            held_full = 1'b0;
            held_half = '0;
          end
        end
        default: ;
      endcase
    endfunction

    function void note_beat(bit [1:0] cmd, bit [AddrW-1:0] a, bit [WordW-1:0] d);
      cpu_result_t    r;
      bit             ran;
      bit [WordW-1:0] word;
      bit [HalfW-1:0] half;
      r   = '0;
      ran = 1'b0;
      case (cmd)
        OpWrite: store_word(a, d);
        OpRead:  r.read_data = load_word(a);
        OpExec: begin
          if (!halt) begin
            if (held_full) begin
              half      = held_half;
              held_full = 1'b0;
              held_half = '0;
              pc        = pc + 1'b1;
              run_instr(half[HalfW-1:AddrW], half[AddrW-1:0]);
              ran = 1'b1;
            end else begin
              mar  = pc;
              word = load_word(pc);
              mbr  = word;
              if (word == '0) begin
                halt = 1'b1;
              end else if (word[HalfW-1:0] != '0) begin
                held_half = word[WordW-1:HalfW];
                held_full = 1'b1;
                run_instr(word[HalfW-1:AddrW], word[AddrW-1:0]);
                ran = 1'b1;
              end else begin
                pc = pc + 1'b1;
                run_instr(word[WordW-1:HalfW+AddrW], word[HalfW+AddrW-1:HalfW]);
                ran = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
      r.prog_counter = pc;
      if (ran) begin
        r.opcode_now   = ir;
        r.operand_addr = mar;
      end
      r.accum       = acc;
      r.buffer_word = mbr;
      r.executed    = ran;
      r.halted      = halt;
      expected_q.push_back(r);
    endfunction

    function void cmp_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_beat(cpu_result_t got);
      cpu_result_t want;
      if (expected_q.size() == 0) begin
        $error("result beat with no command outstanding");
        errors++;
        return;
      end
      want = expected_q.pop_front();
      cmp_field("read_data",    want.read_data,    got.read_data);
      cmp_field("prog_counter", want.prog_counter, got.prog_counter);
      cmp_field("opcode_now",   want.opcode_now,   got.opcode_now);
      cmp_field("operand_addr", want.operand_addr, got.operand_addr);
      cmp_field("accum",        want.accum,        got.accum);
      cmp_field("buffer_word",  want.buffer_word,  got.buffer_word);
      cmp_field("executed",     want.executed,     got.executed);
      cmp_field("halted",       want.halted,       got.halted);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  fbac_in_if  in_if ();
  fbac_out_if out_if ();

  forty_bit_accumulator_cpu_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  cpu_scoreboard sb = new;
  int            idle_pct;
  int            stall_pct;
  int            beats_sent;
  int unsigned   cycles;

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_if.ready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    cpu_result_t got;
    if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      got.read_data    = out_if.read_data;
      got.prog_counter = out_if.prog_counter;
      got.opcode_now   = out_if.opcode_now;
      got.operand_addr = out_if.operand_addr;
      got.accum        = out_if.accum;
      got.buffer_word  = out_if.buffer_word;
      got.executed     = out_if.executed;
      got.halted       = out_if.halted;
      sb.check_beat(got);
    end
  end

  function automatic bit [HalfW-1:0] ins(bit [OpcW-1:0] o, bit [AddrW-1:0] a);
    return {o, a};
  endfunction

  function automatic bit [WordW-1:0] rand_word();
    bit [63:0] w;
    w = {$urandom(), $urandom()};
    case ($urandom_range(0, 7))
      0:       w = '0;
      1:       w[WordW-1:0] = '1;
      2:       w[WordW-1:0] = 40'h80_0000_0000;
      3:       w[WordW-1:0] = 40'h7F_FFFF_FFFF;
      4:       w = 64'd1;
      default: ;
    endcase
    return w[WordW-1:0];
  endfunction

  // Most operands point into a four-word data block, jumps back into the program.
  function automatic bit [HalfW-1:0] rand_half(bit [AddrW-1:0] base, int n,
                                               bit [AddrW-1:0] dbase);
    bit [AddrW-1:0] dat_a;
    bit [AddrW-1:0] jmp_a;
    bit [HalfW-1:0] h;
    dat_a = dbase + AddrW'($urandom_range(0, 3));
    jmp_a = base + AddrW'($urandom_range(0, n - 1));
    case ($urandom_range(0, 9))
      0, 1:    h = ins(OpcLoad, dat_a);
      2:       h = ins(OpcAdd, dat_a);
      3:       h = ins(OpcSub, dat_a);
      4:       h = ins(OpcStor, dat_a);
      5, 6:    h = ins(OpcJump, jmp_a);
      7:       h = ins(OpcW'($urandom), AddrW'($urandom));
      default: h = ins(OpcAdd, AddrW'($urandom));
    endcase
    return h;
  endfunction

  function automatic bit [WordW-1:0] rand_prog_word(bit [AddrW-1:0] base, int n,
                                                    bit [AddrW-1:0] dbase);
    bit [HalfW-1:0] lo;
    bit [HalfW-1:0] hi;
    bit [WordW-1:0] w;
    lo = ($urandom_range(0, 9) < 3) ? '0 : rand_half(base, n, dbase);
    hi = ($urandom_range(0, 9) == 0) ? '0 : rand_half(base, n, dbase);
    w  = {hi, lo};
    // never hand the machine a zero word by accident
    if (w == '0) w = {ins(OpcLoad, dbase), {HalfW{1'b0}}};
    return w;
  endfunction

  // Entered right after the previous beat was taken; leaves valid high.
  task automatic send_beat(logic [1:0] cmd, logic [AddrW-1:0] a, logic [WordW-1:0] d);
    int gap;
    @(negedge clk_i);
    gap = 0;
    while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct && gap < 20) gap++;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.op    <= cmd;
    in_if.addr  <= a;
    in_if.data  <= d;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    sb.note_beat(cmd, a, d);
    if (cmd != OpUnused) beats_sent++;
  endtask

  task automatic bus_idle();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
  endtask

  // Make sure the next execute touches only written, nonzero program words.
  task automatic run_exec();
    bit [WordW-1:0] word;
    bit [HalfW-1:0] half;
    bit [OpcW-1:0]  opc;
    if (!sb.halt) begin
      if (sb.held_full) begin
        half = sb.held_half;
      end else begin
        if (!sb.written[sb.pc] || sb.store[sb.pc] == '0)
          send_beat(OpWrite, sb.pc, rand_prog_word(sb.pc, 1, AddrW'($urandom)));
        word = sb.store[sb.pc];
        half = (word[HalfW-1:0] != '0) ? word[HalfW-1:0] : word[WordW-1:HalfW];
      end
      opc = half[HalfW-1:AddrW];
      if ((opc == OpcLoad || opc == OpcAdd || opc == OpcSub) && !sb.written[half[AddrW-1:0]])
        send_beat(OpWrite, half[AddrW-1:0], rand_word());
    end
    send_beat(OpExec, AddrW'($urandom), rand_word());
  endtask

  task automatic directed_program();
    int i;
    send_beat(OpWrite, 12'h100, 40'h7F_FFFF_FFFF);
    send_beat(OpWrite, 12'h101, 40'h00_0000_0001);
    send_beat(OpWrite, 12'hFFF, 40'hFF_FFFF_FFFF);
    send_beat(OpRead,  12'hFFF, 40'h0);
    // load max positive, add one to overflow negative, subtract back
    send_beat(OpWrite, 12'h000, {ins(OpcAdd, 12'h101), ins(OpcLoad, 12'h100)});
    send_beat(OpWrite, 12'h001, {ins(OpcJump, 12'h003), ins(OpcSub, 12'h101)});
    // taken jump in the low half drops the buffered store
    send_beat(OpWrite, 12'h003, {ins(OpcStor, 12'h102), ins(OpcJump, 12'h006)});
    send_beat(OpWrite, 12'h006, {ins(OpcSub, 12'h100), {HalfW{1'b0}}});
    // jump on negative accumulator falls through
    send_beat(OpWrite, 12'h007, {ins(OpcJump, 12'h000), ins(OpcSub, 12'h101)});
    // zero high half still runs from the buffer and advances
    send_beat(OpWrite, 12'h008, {{HalfW{1'b0}}, ins(OpcStor, 12'h102)});
    send_beat(OpWrite, 12'h009, {ins(OpcAdd, 12'h101), {HalfW{1'b0}}});
    // jump to the last word, whose buffered half wraps the counter
    send_beat(OpWrite, 12'h00A, {ins(OpcJump, 12'hFFF), {HalfW{1'b0}}});
    for (i = 0; i < 14; i++) run_exec();
    send_beat(OpRead, 12'h102, 40'h0);
    send_beat(OpUnused, 12'hFFF, 40'hFF_FFFF_FFFF);
  endtask

  task automatic program_segment();
    int             n;
    int             steps;
    int             i;
    bit [AddrW-1:0] base;
    bit [AddrW-1:0] dbase;
    while (sb.held_full && !sb.halt) run_exec();
    n     = $urandom_range(2, 8);
    base  = sb.pc;
    dbase = AddrW'($urandom);
    for (i = 0; i < 4; i++) send_beat(OpWrite, dbase + AddrW'(i), rand_word());
    for (i = 0; i < n; i++)
      send_beat(OpWrite, base + AddrW'(i), rand_prog_word(base, n, dbase));
    steps = $urandom_range(n, 4 * n);
    for (i = 0; i < steps; i++) begin
      run_exec();
      if ($urandom_range(0, 9) == 0)
        send_beat(OpRead, dbase + AddrW'($urandom_range(0, 3)), rand_word());
    end
  endtask

  task automatic noise_segment();
    int             k;
    int             i;
    bit [AddrW-1:0] a;
    k = $urandom_range(1, 6);
    for (i = 0; i < k; i++) begin
      a = AddrW'($urandom);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: send_beat(OpWrite, a, rand_word());
        4, 5, 6, 7: begin
          if (!sb.written[a]) send_beat(OpWrite, a, rand_word());
          send_beat(OpRead, a, rand_word());
        end
        8:          send_beat(OpUnused, a, rand_word());
        default:    run_exec();
      endcase
    end
  endtask

  task automatic random_phase(int quota);
    int stop_at;
    stop_at = beats_sent + quota;
    while (beats_sent < stop_at) begin
      if ($urandom_range(0, 3) != 0) program_segment();
      else noise_segment();
    end
  endtask

  // Fetch a zero word, then confirm execute is dead while host access still works.
  task automatic halt_check();
    bit [AddrW-1:0] a;
    while (sb.held_full) run_exec();
    a = sb.pc;
    send_beat(OpWrite, a, '0);
    send_beat(OpExec, AddrW'($urandom), rand_word());
    send_beat(OpExec, AddrW'($urandom), rand_word());
    send_beat(OpWrite, a, rand_prog_word(a, 1, a));
    send_beat(OpRead, a, rand_word());
    send_beat(OpExec, AddrW'($urandom), rand_word());
  endtask

  initial begin
    int ph;
    in_if.valid  = 1'b0;
    in_if.op     = OpWrite;
    in_if.addr   = '0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    idle_pct     = 0;
    stall_pct    = 0;
    rst_ni       = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 50; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 50; end
        default: begin idle_pct = 25; stall_pct = 25; end
      endcase
      if (ph == 0) directed_program();
      random_phase(450);
      if (ph == 3) halt_check();
      // hold off until the block has answered everything
      bus_idle();
      while (sb.expected_q.size() != 0) @(negedge clk_i);
    end
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
